FILE: rtl/core/riscv_control_flow_decoder_macros.svh
// Assertion macros shared by the control-flow decoder checkers.
`ifndef RISCV_CONTROL_FLOW_DECODER_MACROS_SVH
`define RISCV_CONTROL_FLOW_DECODER_MACROS_SVH

// Same-cycle implication, masked while reset is held.
`define RCFD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("control-flow decoder check failed");

// Next-cycle implication, masked while reset is held.
`define RCFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("control-flow decoder check failed");

`endif

FILE: rtl/core/rcfd_pkg.sv
// Types, encodings and constants for the RISC-V control-flow decoder.
package rcfd_pkg;

    typedef enum logic [1:0] {
        JK_NONE     = 2'd0,
        JK_BRANCH   = 2'd1,
        JK_DIRECT   = 2'd2,
        JK_REGISTER = 2'd3
    } t_jump_kind;

    typedef enum logic [1:0] {
        AK_NONE = 2'd0,
        AK_AMO  = 2'd1,
        AK_LR   = 2'd2,
        AK_SC   = 2'd3
    } t_atomic_kind;

    // 32-bit opcodes
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_JAL    = 7'h6f;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_AMO    = 7'h2f;

    // Atomic funct5 codes
    localparam logic [4:0] F5_LR = 5'b00010;
    localparam logic [4:0] F5_SC = 5'b00011;

    // Compressed masks and matches
    localparam logic [15:0] CMASK_TOP = 16'he003;
    localparam logic [15:0] CMASK_CR  = 16'hf003;
    localparam logic [15:0] C_BEQZ    = 16'hc001;
    localparam logic [15:0] C_BNEZ    = 16'he001;
    localparam logic [15:0] C_J       = 16'ha001;
    localparam logic [15:0] C_JAL     = 16'h2001;
    localparam logic [15:0] C_JR      = 16'h8002;
    localparam logic [15:0] C_JALR    = 16'h9002;

    localparam logic [1:0] LOW_FULL   = 2'b11;
    localparam logic [4:0] REG_ZERO   = 5'd0;
    localparam logic [4:0] REG_RA     = 5'd1;
    localparam logic [4:0] CREG_BASE  = 5'd8;
    localparam logic [2:0] COND_BEQ   = 3'd0;
    localparam logic [2:0] COND_BNE   = 3'd1;

    typedef struct packed {
        t_jump_kind   jump_kind;
        logic         is_compressed;
        logic         is_call;
        logic [4:0]   link_reg;
        logic [2:0]   branch_cond;
        logic [4:0]   reg_a;
        logic [4:0]   reg_b;
        logic [31:0]  offset;
        logic [63:0]  target;
        logic         target_valid;
        t_atomic_kind atomic_kind;
        logic         is_auipc;
    } t_decode;

endpackage

FILE: rtl/core/riscv_control_flow_decoder.sv
// Top level of the RISC-V branch, jump, auipc and atomic decoder.
// The decoder takes one instruction word and its pc per cycle while o_stall is
// low and returns one decoded word per input word. An accepted word is held in
// an input register, classified and its pc-relative target formed in the
// following cycle, and the result lands in an output register: o_valid rises
// when the word moves from the input register into the output register, and a
// new word can be accepted every cycle while o_stall is low. The
// critical path is the field extraction feeding one 64-bit adder (pc plus
// sign-extended offset) between the two registers. Compressed words (low two
// bits not 11) are decoded from bits 15:0 only. c.beqz/c.bnez, c.j/c.jal and
// c.jr/c.jalr are recognized; c.jr/c.jalr need rs2 zero and rs1 nonzero.
// Fields that do not apply to the word's class read as zero. o_stall follows
// i_stall through the two stages, so a full pipe backs up in the same cycle
// without losing a word.
module riscv_control_flow_decoder
    import rcfd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [31:0]        i_insn,
    input  logic [63:0]        i_pc,
    // result channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_jump_kind,
    output logic               o_is_compressed,
    output logic               o_is_call,
    output logic [4:0]         o_link_reg,
    output logic [2:0]         o_branch_cond,
    output logic [4:0]         o_reg_a,
    output logic [4:0]         o_reg_b,
    output logic signed [31:0] o_offset,
    output logic [63:0]        o_target,
    output logic               o_target_valid,
    output logic [1:0]         o_atomic_kind,
    output logic               o_is_auipc
);

    logic        r_in_valid;
    logic [31:0] r_insn;
    logic [63:0] r_pc;
    logic        r_out_valid;
    t_decode     r_res;
    t_decode     n_res;

    logic        out_load;
    logic        in_load;

    logic [15:0] cw;
    logic [15:0] c_top;
    logic [15:0] c_cr;
    logic [6:0]  opc;

    // Advance the output stage when it is empty or its word is being taken;
    // advance the input stage when it is empty or its word moves on.
    assign out_load = !r_out_valid || !i_stall;
    assign in_load  = !r_in_valid || out_load;
    assign o_stall  = !in_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= i_valid;
        end
    end

    // Hold the captured word while the next stage is blocked.
    always_ff @(posedge i_clk) begin
        if (in_load && i_valid) begin
            r_insn <= i_insn;
            r_pc   <= i_pc;
        end
    end

    assign cw    = r_insn[15:0];
    assign c_top = cw & CMASK_TOP;
    assign c_cr  = cw & CMASK_CR;
    assign opc   = r_insn[6:0];

    // Decode: every field defaults to zero and is filled per class.
    always_comb begin
        n_res               = '0;
        n_res.jump_kind     = JK_NONE;
        n_res.atomic_kind   = AK_NONE;
        n_res.is_compressed = (r_insn[1:0] != LOW_FULL);

        if (n_res.is_compressed) begin
            unique case (c_top) inside
                C_BEQZ, C_BNEZ: begin
                    n_res.jump_kind   = JK_BRANCH;
                    n_res.branch_cond = (c_top == C_BNEZ) ? COND_BNE : COND_BEQ;
                    // rs1' selects x8..x15
                    n_res.reg_a       = CREG_BASE + {2'b00, cw[9:7]};
                    n_res.offset      = {{23{cw[12]}}, cw[12], cw[6:5], cw[2],
                                         cw[11:10], cw[4:3], 1'b0};
                end
                C_J, C_JAL: begin
                    n_res.jump_kind = JK_DIRECT;
                    n_res.link_reg  = (c_top == C_JAL) ? REG_RA : REG_ZERO;
                    n_res.offset    = {{20{cw[12]}}, cw[12], cw[8], cw[10:9], cw[6],
                                       cw[7], cw[2], cw[11], cw[5:3], 1'b0};
                end
                default: begin
                    // c.jr / c.jalr: rs2 must be zero and rs1 nonzero
                    if ((c_cr == C_JR || c_cr == C_JALR) && cw[6:2] == REG_ZERO
                        && cw[11:7] != REG_ZERO) begin
                        n_res.jump_kind = JK_REGISTER;
                        n_res.link_reg  = (c_cr == C_JALR) ? REG_RA : REG_ZERO;
                        n_res.reg_a     = cw[11:7];
                    end
                end
            endcase
        end else begin
            unique case (opc)
                OPC_BRANCH: begin
                    n_res.jump_kind   = JK_BRANCH;
                    n_res.branch_cond = r_insn[14:12];
                    n_res.reg_a       = r_insn[19:15];
                    n_res.reg_b       = r_insn[24:20];
                    n_res.offset      = {{19{r_insn[31]}}, r_insn[31], r_insn[7],
                                         r_insn[30:25], r_insn[11:8], 1'b0};
                end
                OPC_JAL: begin
                    n_res.jump_kind = JK_DIRECT;
                    n_res.link_reg  = r_insn[11:7];
                    n_res.offset    = {{11{r_insn[31]}}, r_insn[31], r_insn[19:12],
                                       r_insn[20], r_insn[30:21], 1'b0};
                end
                OPC_JALR: begin
                    n_res.jump_kind = JK_REGISTER;
                    n_res.link_reg  = r_insn[11:7];
                    n_res.reg_a     = r_insn[19:15];
                    n_res.offset    = {{20{r_insn[31]}}, r_insn[31:20]};
                end
                OPC_AUIPC: begin
                    n_res.is_auipc = 1'b1;
                    n_res.reg_a    = r_insn[11:7];
                    n_res.offset   = {r_insn[31:12], 12'h000};
                end
                OPC_AMO: begin
                    if (r_insn[31:27] == F5_LR) begin
                        n_res.atomic_kind = AK_LR;
                    end else if (r_insn[31:27] == F5_SC) begin
                        n_res.atomic_kind = AK_SC;
                    end else begin
                        n_res.atomic_kind = AK_AMO;
                    end
                end
                default: begin
                end
            endcase
        end

        // pc-relative target for branches and direct jumps only
        if (n_res.jump_kind == JK_BRANCH || n_res.jump_kind == JK_DIRECT) begin
            n_res.target_valid = 1'b1;
            n_res.target       = r_pc + {{32{n_res.offset[31]}}, n_res.offset};
        end

        n_res.is_call = (n_res.jump_kind == JK_DIRECT || n_res.jump_kind == JK_REGISTER)
                        && n_res.link_reg == REG_RA;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    // Hold the result word while the consumer stalls.
    always_ff @(posedge i_clk) begin
        if (out_load && r_in_valid) begin
            r_res <= n_res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_jump_kind     = r_res.jump_kind;
    assign o_is_compressed = r_res.is_compressed;
    assign o_is_call       = r_res.is_call;
    assign o_link_reg      = r_res.link_reg;
    assign o_branch_cond   = r_res.branch_cond;
    assign o_reg_a         = r_res.reg_a;
    assign o_reg_b         = r_res.reg_b;
    assign o_offset        = $signed(r_res.offset);
    assign o_target        = r_res.target;
    assign o_target_valid  = r_res.target_valid;
    assign o_atomic_kind   = r_res.atomic_kind;
    assign o_is_auipc      = r_res.is_auipc;

endmodule

FILE: rtl/core/rcfd_checker.sv
// Port-level checker for the RISC-V control-flow decoder and its bind.
`include "riscv_control_flow_decoder_macros.svh"

module rcfd_checker
    import rcfd_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic [31:0]        i_insn,
    input logic [63:0]        i_pc,
    input logic               o_valid,
    input logic               i_stall,
    input logic [1:0]         o_jump_kind,
    input logic               o_is_compressed,
    input logic               o_is_call,
    input logic [4:0]         o_link_reg,
    input logic [2:0]         o_branch_cond,
    input logic [4:0]         o_reg_a,
    input logic [4:0]         o_reg_b,
    input logic signed [31:0] o_offset,
    input logic [63:0]        o_target,
    input logic               o_target_valid,
    input logic [1:0]         o_atomic_kind,
    input logic               o_is_auipc
);

    logic        out_jump;
    logic        out_rel;
    logic        call_ok;
    logic        auipc_ok;
    logic [95:0] out_word;

    assign out_jump = (o_jump_kind == JK_DIRECT || o_jump_kind == JK_REGISTER);
    assign out_rel  = (o_jump_kind == JK_BRANCH || o_jump_kind == JK_DIRECT);
    assign call_ok  = (o_link_reg == REG_RA) && out_jump;
    assign auipc_ok = !o_is_compressed && o_jump_kind == JK_NONE && o_atomic_kind == AK_NONE;
    assign out_word = {o_target, o_offset};

    // A call always links through ra from a jump.
    `RCFD_ASSERT_NOW(a_call_links_ra, i_clk, i_rst_n, o_valid && o_is_call, call_ok)

    // Target is valid exactly for branches and direct jumps.
    `RCFD_ASSERT_NOW(a_target_class, i_clk, i_rst_n, o_valid, o_target_valid == out_rel)

    // auipc is a full-width word and excludes jumps and atomics.
    `RCFD_ASSERT_NOW(a_auipc_excl, i_clk, i_rst_n, o_valid && o_is_auipc, auipc_ok)

    // A stalled result stays presented with the same target.
    `RCFD_ASSERT_NEXT(a_hold_result, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(out_word))

endmodule

bind riscv_control_flow_decoder rcfd_checker u_rcfd_checker (.*);
